// File: sv/chm_pkg.sv
package chm_pkg;

	localparam int MAX_BLOCKS_DEF   = 64;
	localparam int BLOCK_BYTES_DEF  = 64;
	localparam int ADDRESS_BITS_DEF = 32;

	localparam int ADDR_W     = 32;
	localparam int COUNT_W    = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MAPPING  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPLIT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLK_LOG2 = 2'd2;

	localparam logic       MAP_DIRECT   = 1'b0;
	localparam logic [2:0] BLK_LOG2_RST = 3'd6;

	typedef struct packed {
		logic start;
		logic issue;
		logic update;
		logic load;
	} dp_cmd_t;

	typedef struct packed {
		logic all_issued;
		logic pending;
		logic match;
	} dp_sts_t;

endpackage

// File: sv/chm_ctrl.sv
module chm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  chm_pkg::dp_sts_t sts,
	output chm_pkg::dp_cmd_t cmd
);
	import chm_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_UPDATE = 2'd2;
	localparam logic [1:0] S_DONE   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.issue = !sts.all_issued;
				if (sts.match || (sts.all_issued && !sts.pending)) begin
					state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/chm_datapath.sv
module chm_datapath #(
	parameter int MAX_BLOCKS   = chm_pkg::MAX_BLOCKS_DEF,
	parameter int BLOCK_BYTES  = chm_pkg::BLOCK_BYTES_DEF,
	parameter int ADDRESS_BITS = chm_pkg::ADDRESS_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  chm_pkg::dp_cmd_t               cmd,
	output chm_pkg::dp_sts_t               sts,
	input  logic [chm_pkg::ADDR_W-1:0]     address,
	input  logic                           kind,
	input  logic                           cfg_we,
	input  logic [chm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [chm_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                           hit,
	output logic [chm_pkg::COUNT_W-1:0]    access_total,
	output logic [chm_pkg::COUNT_W-1:0]    hit_total
);
	import chm_pkg::*;

	localparam int AW       = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
	localparam int OFF_BITS = $clog2(BLOCK_BYTES + 1) - 1;
	localparam int TAG_W    = AW - OFF_BITS;
	localparam int MAX_LOG  = $clog2(MAX_BLOCKS + 1) - 1;
	localparam int IDX_W    = (MAX_LOG > 0) ? MAX_LOG : 1;
	localparam int CNT_W    = MAX_LOG + 1;
	localparam int ENTRIES  = 2 * MAX_BLOCKS;
	localparam int ENT_W    = $clog2(ENTRIES);

	// configuration
	logic       map_q;
	logic       split_q;
	logic [2:0] blog_q;

	// transaction context
	logic             fa_q;
	logic             cache_q;
	logic [TAG_W-1:0] tag_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] mask_q;
	logic [CNT_W-1:0] n_q;
	logic [ENT_W-1:0] base_q;
	logic [CNT_W-1:0] cnt_q;
	logic             hit_q;

	logic [IDX_W-1:0]   ptr_q [2];
	logic [ENTRIES-1:0] vld_q;
	logic [TAG_W-1:0]   tag_mem [ENTRIES];

	logic [TAG_W-1:0] rdata_s1;
	logic             vld_s1;
	logic             pending_s1;

	logic [COUNT_W-1:0] acc_q;
	logic [COUNT_W-1:0] hitc_q;

	// lookup setup
	logic [TAG_W-1:0]       ba;
	logic [TAG_W+IDX_W-1:0] ba_ext;
	logic [2:0]             lg;
	logic [CNT_W-1:0]       nblk;
	logic [CNT_W-1:0]       nmask;
	logic [IDX_W-1:0]       mask_c;
	logic                   cache_c;

	assign ba      = address[AW-1:OFF_BITS];
	assign ba_ext  = {{IDX_W{1'b0}}, ba};
	assign lg      = (int'(blog_q) > MAX_LOG) ? 3'(MAX_LOG) : blog_q;
	assign nblk    = CNT_W'(1) << lg;
	assign nmask   = nblk - CNT_W'(1);
	assign mask_c  = nmask[IDX_W-1:0];
	assign cache_c = split_q & kind;

	// entry addressing
	logic [IDX_W-1:0] rd_off;
	logic [ENT_W-1:0] rd_ent;
	logic [IDX_W-1:0] wr_off;
	logic [ENT_W-1:0] wr_ent;
	logic [IDX_W-1:0] ptr_next;
	logic             miss_wr;

	assign rd_off   = fa_q ? cnt_q[IDX_W-1:0] : idx_q;
	assign rd_ent   = base_q + ENT_W'(rd_off);
	assign wr_off   = fa_q ? (ptr_q[cache_q] & mask_q) : idx_q;
	assign wr_ent   = base_q + ENT_W'(wr_off);
	assign ptr_next = (wr_off + IDX_W'(1)) & mask_q;
	assign miss_wr  = cmd.update && !hit_q;

	assign sts.match      = pending_s1 && vld_s1 && (rdata_s1 == tag_q);
	assign sts.pending    = pending_s1;
	assign sts.all_issued = (cnt_q == n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q   <= MAP_DIRECT;
			split_q <= 1'b0;
			blog_q  <= BLK_LOG2_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAPPING:  map_q   <= cfg_data[0];
				REG_SPLIT:    split_q <= cfg_data[0];
				REG_BLK_LOG2: blog_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			fa_q    <= map_q;
			cache_q <= cache_c;
			tag_q   <= map_q ? ba : (ba >> lg);
			idx_q   <= ba_ext[IDX_W-1:0] & mask_c;
			mask_q  <= mask_c;
			n_q     <= map_q ? nblk : CNT_W'(1);
			base_q  <= cache_c ? ENT_W'(MAX_BLOCKS) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			hit_q      <= 1'b0;
			pending_s1 <= 1'b0;
			vld_s1     <= 1'b0;
			vld_q      <= '0;
			ptr_q[0]   <= '0;
			ptr_q[1]   <= '0;
			acc_q      <= '0;
			hitc_q     <= '0;
		end else begin
			pending_s1 <= cmd.issue;
			if (cmd.issue) begin
				vld_s1 <= vld_q[rd_ent];
			end
			if (cmd.start) begin
				cnt_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (cmd.issue) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (sts.match) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.update) begin
				acc_q  <= acc_q + COUNT_W'(1);
				hitc_q <= hitc_q + COUNT_W'(hit_q);
			end
			if (miss_wr) begin
				vld_q[wr_ent] <= 1'b1;
				if (fa_q) begin
					ptr_q[cache_q] <= ptr_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (miss_wr) begin
			tag_mem[wr_ent] <= tag_q;
		end
		if (cmd.issue) begin
			rdata_s1 <= tag_mem[rd_ent];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hit          <= hit_q;
			access_total <= acc_q;
			hit_total    <= hitc_q;
		end
	end

endmodule

// File: sv/cache_hit_miss_model_unit.sv
// Channel   Signals                                       Direction
// in        in_valid, in_ready, address, kind             into block
// out       out_valid, out_ready, hit, access_total,      out of block
//           hit_total
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data     into block
//
// One transaction at a time; the tag memory is read one entry per cycle.
// Direct mapped: each transaction reads the single indexed entry. Fully
// associative: a miss scans all N entries, N = blocks in use (2**BLK_LOG2,
// at most MAX_BLOCKS); a hit at entry k ends the scan early.
// Reset clears valid bits, FIFO pointers and counters and sets the configuration to its reset values at once.
// A stalled result is held in the output register; the next input is taken.
module cache_hit_miss_model_unit #(
	parameter int MAX_BLOCKS   = chm_pkg::MAX_BLOCKS_DEF,
	parameter int BLOCK_BYTES  = chm_pkg::BLOCK_BYTES_DEF,
	parameter int ADDRESS_BITS = chm_pkg::ADDRESS_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [chm_pkg::ADDR_W-1:0]     address,
	input  logic                           kind,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           hit,
	output logic [chm_pkg::COUNT_W-1:0]    access_total,
	output logic [chm_pkg::COUNT_W-1:0]    hit_total,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [chm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [chm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import chm_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	assign cfg_ready = 1'b1;

	chm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	chm_datapath #(
		.MAX_BLOCKS   (MAX_BLOCKS),
		.BLOCK_BYTES  (BLOCK_BYTES),
		.ADDRESS_BITS (ADDRESS_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.address      (address),
		.kind         (kind),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.hit          (hit),
		.access_total (access_total),
		.hit_total    (hit_total)
	);

endmodule
